// ===== src/double_ended_queue_macros.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_macros
// assertion macros used by the deque datapath
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define DEQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// types and codes shared by the deque controller, datapath and top level
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int CmdW    = 3;
  localparam int PosW    = 4;
  localparam int WordW   = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_READ_AT    = 3'd6
  } deq_cmd_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } deq_status_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [PosW-1:0]  position;
    logic [WordW-1:0] data_in;
  } deq_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   data_out;
    logic [CountW-1:0]  count;
  } deq_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RD_WAIT,
    ST_SU_RD,
    ST_SU_WR,
    ST_SD_RD,
    ST_SD_WR,
    ST_DONE
  } deq_state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_CNT_M1,
    RD_POS,
    RD_IDX_M1,
    RD_IDX
  } deq_rsel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_TAIL,
    WR_POS,
    WR_UP,
    WR_DN
  } deq_wsel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } deq_cnt_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_FROM_CNT,
    IDX_FROM_POS,
    IDX_INC,
    IDX_DEC
  } deq_idx_e;

  typedef struct packed {
    logic      load;
    deq_rsel_e rsel;
    deq_wsel_e wsel;
    deq_cnt_e  cnt;
    deq_idx_e  idx;
    logic      capture;
    logic      out_load;
  } deq_ctrl_t;

  typedef struct packed {
    deq_cmd_e cmd;
    logic     err;
    logic     idx_at_pos;
    logic     idx_at_end;
    logic     out_free;
  } deq_stat_t;

endpackage

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// fixed-capacity deque with push, pop, insert, erase and read at a position
// ----------------------------------------------------------------------------
//  channel  | signals                          | beat
//  ---------+----------------------------------+------------------------------
//  in       | in_valid_i in_ready_o in_data_i  | cmd, position, data_in
//  out      | out_valid_o out_ready_i out_data_o | status, data_out, count
//
//  one command at a time; insert, push front, erase and pop front shift
//  entries through the single entry memory one entry at a time, with a
//  read state then a write state per entry
//  reset clears the count, index, result valid and state; the entry memory is not cleared
//  a new command is taken while the previous result still waits on out
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  deq_pkg::deq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_out_t out_data_o
);

  deq_pkg::deq_ctrl_t ctrl;
  deq_pkg::deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

// ===== src/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// command sequencer: decides each command and steps the shift loops
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  deq_pkg::deq_stat_t stat_i,
  output deq_pkg::deq_ctrl_t ctrl_o
);

  deq_pkg::deq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    ctrl_o         = '0;
    ctrl_o.rsel    = deq_pkg::RD_NONE;
    ctrl_o.wsel    = deq_pkg::WR_NONE;
    ctrl_o.cnt     = deq_pkg::CNT_HOLD;
    ctrl_o.idx     = deq_pkg::IDX_HOLD;
    unique case (state_q)
      deq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = deq_pkg::ST_DECIDE;
        end
      end
      deq_pkg::ST_DECIDE: begin
        if (stat_i.err) begin
          state_d = deq_pkg::ST_DONE;
        end else begin
          unique case (stat_i.cmd) inside
            deq_pkg::CMD_PUSH_BACK: begin
              ctrl_o.wsel = deq_pkg::WR_TAIL;
              ctrl_o.cnt  = deq_pkg::CNT_INC;
              state_d     = deq_pkg::ST_DONE;
            end
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_INSERT: begin
              ctrl_o.idx = deq_pkg::IDX_FROM_CNT;
              state_d    = deq_pkg::ST_SU_RD;
            end
            deq_pkg::CMD_POP_BACK: begin
              ctrl_o.rsel = deq_pkg::RD_CNT_M1;
              ctrl_o.cnt  = deq_pkg::CNT_DEC;
              state_d     = deq_pkg::ST_RD_WAIT;
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_READ_AT: begin
              ctrl_o.rsel = deq_pkg::RD_POS;
              state_d     = deq_pkg::ST_RD_WAIT;
            end
            deq_pkg::CMD_ERASE: begin
              ctrl_o.idx = deq_pkg::IDX_FROM_POS;
              state_d    = deq_pkg::ST_SD_RD;
            end
            default: begin
              state_d = deq_pkg::ST_DONE;
            end
          endcase
        end
      end
      deq_pkg::ST_RD_WAIT: begin
        ctrl_o.capture = 1'b1;
        if (stat_i.cmd == deq_pkg::CMD_POP_FRONT) begin
          ctrl_o.idx = deq_pkg::IDX_FROM_POS;
          state_d    = deq_pkg::ST_SD_RD;
        end else begin
          state_d = deq_pkg::ST_DONE;
        end
      end
      deq_pkg::ST_SU_RD: begin
        if (stat_i.idx_at_pos) begin
          ctrl_o.wsel = deq_pkg::WR_POS;
          ctrl_o.cnt  = deq_pkg::CNT_INC;
          state_d     = deq_pkg::ST_DONE;
        end else begin
          ctrl_o.rsel = deq_pkg::RD_IDX_M1;
          state_d     = deq_pkg::ST_SU_WR;
        end
      end
      deq_pkg::ST_SU_WR: begin
        ctrl_o.wsel = deq_pkg::WR_UP;
        ctrl_o.idx  = deq_pkg::IDX_DEC;
        state_d     = deq_pkg::ST_SU_RD;
      end
      deq_pkg::ST_SD_RD: begin
        if (stat_i.idx_at_end) begin
          ctrl_o.cnt = deq_pkg::CNT_DEC;
          state_d    = deq_pkg::ST_DONE;
        end else begin
          ctrl_o.rsel = deq_pkg::RD_IDX;
          state_d     = deq_pkg::ST_SD_WR;
        end
      end
      deq_pkg::ST_SD_WR: begin
        ctrl_o.wsel = deq_pkg::WR_DN;
        ctrl_o.idx  = deq_pkg::IDX_INC;
        state_d     = deq_pkg::ST_SD_RD;
      end
      deq_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// deq_datapath
// entry memory, count and index registers, status check and result register
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module deq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  deq_pkg::deq_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output deq_pkg::deq_out_t  out_data_o,
  input  deq_pkg::deq_ctrl_t ctrl_i,
  output deq_pkg::deq_stat_t stat_o
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int CmpW    = (CW > deq_pkg::PosW) ? CW : deq_pkg::PosW;
  localparam int CntOutW = deq_pkg::CountW;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] res_data_q;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [AW-1:0]         pos_q;
  logic [deq_pkg::CmdW-1:0] cmd_q;
  deq_pkg::deq_status_e  status_q, status_c;
  logic                  out_valid_q;
  deq_pkg::deq_out_t     out_q;

  logic [CmpW-1:0]       pos_ext, cnt_ext;
  logic [CW-1:0]         cnt_m1, idx_m1, pos_cw;
  logic [63:0]           word_ext, res_ext;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  deq_pkg::deq_cmd_e     cmd_in;
  logic                  is_full, is_empty, pos_bad;

  assign cmd_in   = deq_pkg::deq_cmd_e'(in_data_i.cmd);
  assign pos_ext  = (cmd_in == deq_pkg::CMD_PUSH_FRONT || cmd_in == deq_pkg::CMD_POP_FRONT)
                    ? '0 : CmpW'(in_data_i.position);
  assign cnt_ext  = CmpW'(count_q);
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign pos_bad  = (pos_ext >= cnt_ext);
  assign word_ext = 64'(in_data_i.data_in);
  assign res_ext  = 64'(res_data_q);
  assign cnt_m1   = count_q - CW'(1);
  assign idx_m1   = idx_q - CW'(1);
  assign pos_cw   = CW'(pos_q);

  // status of the incoming command against the current count
  always_comb begin
    status_c = deq_pkg::STATUS_OK;
    case (cmd_in) inside
      deq_pkg::CMD_PUSH_BACK, deq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) status_c = deq_pkg::STATUS_FULL;
      end
      deq_pkg::CMD_POP_BACK, deq_pkg::CMD_POP_FRONT: begin
        if (is_empty) status_c = deq_pkg::STATUS_EMPTY;
      end
      deq_pkg::CMD_INSERT: begin
        if (pos_bad) status_c = deq_pkg::STATUS_RANGE;
        else if (is_full) status_c = deq_pkg::STATUS_FULL;
      end
      deq_pkg::CMD_ERASE, deq_pkg::CMD_READ_AT: begin
        if (pos_bad) status_c = deq_pkg::STATUS_RANGE;
      end
      default: begin
        status_c = deq_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q    <= in_data_i.cmd;
      pos_q    <= pos_ext[AW-1:0];
      word_q   <= word_ext[DATA_WIDTH-1:0];
      status_q <= status_c;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = rd_data_q;
    unique case (ctrl_i.wsel)
      deq_pkg::WR_TAIL: begin
        wr_addr = count_q[AW-1:0];
        wr_data = word_q;
      end
      deq_pkg::WR_POS: begin
        wr_addr = pos_q;
        wr_data = word_q;
      end
      deq_pkg::WR_UP:   wr_addr = idx_q[AW-1:0];
      deq_pkg::WR_DN:   wr_addr = idx_m1[AW-1:0];
      default:          wr_en   = 1'b0;
    endcase
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (ctrl_i.rsel)
      deq_pkg::RD_CNT_M1: rd_addr = cnt_m1[AW-1:0];
      deq_pkg::RD_POS:    rd_addr = pos_q;
      deq_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
      deq_pkg::RD_IDX:    rd_addr = idx_q[AW-1:0];
      default:            rd_en   = 1'b0;
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    case (ctrl_i.cnt)
      deq_pkg::CNT_INC: count_d = count_q + CW'(1);
      deq_pkg::CNT_DEC: count_d = cnt_m1;
      default:          count_d = count_q;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    case (ctrl_i.idx)
      deq_pkg::IDX_FROM_CNT: idx_d = count_q;
      deq_pkg::IDX_FROM_POS: idx_d = pos_cw + CW'(1);
      deq_pkg::IDX_INC:      idx_d = idx_q + CW'(1);
      deq_pkg::IDX_DEC:      idx_d = idx_m1;
      default:               idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      res_data_q <= '0;
    end else if (ctrl_i.capture) begin
      res_data_q <= rd_data_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q.status   <= status_q;
      out_q.data_out <= res_ext[deq_pkg::WordW-1:0];
      out_q.count    <= CntOutW'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.cmd        = deq_pkg::deq_cmd_e'(cmd_q);
  assign stat_o.err        = (status_q != deq_pkg::STATUS_OK);
  assign stat_o.idx_at_pos = (idx_q == pos_cw);
  assign stat_o.idx_at_end = (idx_q >= count_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  `DEQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
  `DEQ_ASSERT(a_load_holds_count, ctrl_i.load |=> $stable(count_q), "count moved at accept")
  `DEQ_NEVER(a_result_overrun, ctrl_i.out_load && out_valid_q && !out_ready_i, "result overrun")
  `DEQ_NEVER(a_write_range, wr_en && (CW'(wr_addr) > count_q), "write beyond entry count")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the double-ended queue: a queue-based copy of the
// deque predicts status, word and count for every accepted command beat; each
// result beat is compared in order; outside streaming, channels idle at random
// ----------------------------------------------------------------------------
module tb_top;

  localparam int                        Depth      = 16;
  localparam int                        CycleLimit = 600000;
  localparam logic [deq_pkg::CmdW-1:0]  CmdUnused  = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  deq_pkg::deq_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  deq_pkg::deq_out_t out_data;

  logic [deq_pkg::WordW-1:0] deq_words[$];
  deq_pkg::deq_out_t         expected_results[$];
  int                        error_cnt = 0;
  int                        cycle_cnt = 0;
  int                        hold_len = 0;
  bit                        idle_on = 1'b1;
  bit                        stall_on = 1'b1;

  double_ended_queue #(
    .DEPTH      (Depth),
    .DATA_WIDTH (deq_pkg::WordW)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // deque behavior applied to the local copy, returns the result beat
  function automatic deq_pkg::deq_out_t apply_deq_cmd(deq_pkg::deq_in_t beat);
    deq_pkg::deq_out_t r;
    r.status   = deq_pkg::STATUS_OK;
    r.data_out = '0;
    case (beat.cmd)
      deq_pkg::CMD_PUSH_BACK: begin
        if (deq_words.size() >= Depth) r.status = deq_pkg::STATUS_FULL;
        else deq_words.insert(deq_words.size(), beat.data_in);
      end
      deq_pkg::CMD_PUSH_FRONT: begin
        if (deq_words.size() >= Depth) r.status = deq_pkg::STATUS_FULL;
        else deq_words.insert(0, beat.data_in);
      end
      deq_pkg::CMD_POP_BACK: begin
        if (deq_words.size() == 0) begin
          r.status = deq_pkg::STATUS_EMPTY;
        end else begin
          r.data_out = deq_words[$];
          deq_words.delete(deq_words.size() - 1);
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (deq_words.size() == 0) begin
          r.status = deq_pkg::STATUS_EMPTY;
        end else begin
          r.data_out = deq_words[0];
          deq_words.delete(0);
        end
      end
      deq_pkg::CMD_INSERT: begin
        if (beat.position >= deq_words.size()) r.status = deq_pkg::STATUS_RANGE;
        else if (deq_words.size() >= Depth) r.status = deq_pkg::STATUS_FULL;
        else deq_words.insert(beat.position, beat.data_in);
      end
      deq_pkg::CMD_ERASE: begin
        if (beat.position >= deq_words.size()) r.status = deq_pkg::STATUS_RANGE;
        else deq_words.delete(beat.position);
      end
      deq_pkg::CMD_READ_AT: begin
        if (beat.position >= deq_words.size()) r.status = deq_pkg::STATUS_RANGE;
        else r.data_out = deq_words[beat.position];
      end
      default: begin
      end
    endcase
    r.count = deq_pkg::CountW'(deq_words.size());
    return r;
  endfunction

  function automatic deq_pkg::deq_in_t make_beat(logic [deq_pkg::CmdW-1:0] cmd,
                                                 int unsigned pos,
                                                 logic [deq_pkg::WordW-1:0] word);
    deq_pkg::deq_in_t b;
    b.cmd      = cmd;
    b.position = deq_pkg::PosW'(pos);
    b.data_in  = word;
    return b;
  endfunction

  task automatic send_beat(input deq_pkg::deq_in_t beat);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    expected_results.insert(expected_results.size(), apply_deq_cmd(beat));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    deq_pkg::deq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual %h", $time, out_data);
        error_cnt++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          error_cnt++;
        end
        if (out_data.data_out !== want.data_out) begin
          $display("%0t: data_out expected %h actual %h", $time, want.data_out,
                   out_data.data_out);
          error_cnt++;
        end
        if (out_data.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count,
                   out_data.count);
          error_cnt++;
        end
      end
    end
  end

  task automatic test_empty_cases();
    send_beat(make_beat(deq_pkg::CMD_POP_BACK, 0, '1));
    send_beat(make_beat(deq_pkg::CMD_POP_FRONT, 15, '0));
    send_beat(make_beat(deq_pkg::CMD_READ_AT, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_ERASE, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_INSERT, 0, 32'hdead_beef));
    send_beat(make_beat(CmdUnused, 15, '1));
  endtask

  task automatic test_positions();
    send_beat(make_beat(deq_pkg::CMD_PUSH_BACK, 0, 32'ha5a5_a5a5));
    send_beat(make_beat(deq_pkg::CMD_PUSH_FRONT, 0, '1));
    send_beat(make_beat(deq_pkg::CMD_PUSH_BACK, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_READ_AT, 2, '0));
    send_beat(make_beat(deq_pkg::CMD_READ_AT, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_READ_AT, 3, '0));
    send_beat(make_beat(deq_pkg::CMD_INSERT, 0, 32'h5a5a_5a5a));
    send_beat(make_beat(deq_pkg::CMD_INSERT, 3, 32'h1234_5678));
    send_beat(make_beat(deq_pkg::CMD_INSERT, 5, 32'h0bad_f00d));
    send_beat(make_beat(deq_pkg::CMD_ERASE, 4, '0));
    send_beat(make_beat(deq_pkg::CMD_ERASE, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_ERASE, 15, '0));
    send_beat(make_beat(CmdUnused, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_POP_FRONT, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_POP_BACK, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_POP_BACK, 0, '0));
    wait_drained();
  endtask

  // fill to capacity, starting while the result side holds off
  task automatic test_backpressure();
    hold_len = 120;
    for (int i = 0; i < Depth; i++)
      send_beat(make_beat(deq_pkg::CMD_PUSH_BACK, 0, $urandom));
    send_beat(make_beat(deq_pkg::CMD_PUSH_BACK, 0, '1));
    send_beat(make_beat(deq_pkg::CMD_PUSH_FRONT, 0, '1));
    send_beat(make_beat(deq_pkg::CMD_INSERT, 15, '1));
    send_beat(make_beat(deq_pkg::CMD_INSERT, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_READ_AT, 15, '0));
    send_beat(make_beat(deq_pkg::CMD_ERASE, 15, '0));
    send_beat(make_beat(deq_pkg::CMD_READ_AT, 15, '0));
    send_beat(make_beat(deq_pkg::CMD_POP_FRONT, 0, '0));
    send_beat(make_beat(deq_pkg::CMD_INSERT, 14, 32'hffff_0000));
    wait_drained();
  endtask

  function automatic deq_pkg::deq_in_t rand_beat(bit grow);
    deq_pkg::deq_in_t b;
    int unsigned      cnt;
    int unsigned      roll;
    cnt  = deq_words.size();
    roll = $urandom_range(0, 99);
    if (grow) begin
      if (roll < 28) b.cmd = deq_pkg::CMD_PUSH_BACK;
      else if (roll < 50) b.cmd = deq_pkg::CMD_PUSH_FRONT;
      else if (roll < 66) b.cmd = deq_pkg::CMD_INSERT;
      else if (roll < 74) b.cmd = deq_pkg::CMD_POP_BACK;
      else if (roll < 81) b.cmd = deq_pkg::CMD_POP_FRONT;
      else if (roll < 88) b.cmd = deq_pkg::CMD_ERASE;
      else b.cmd = deq_pkg::CMD_READ_AT;
    end else begin
      if (roll < 10) b.cmd = deq_pkg::CMD_PUSH_BACK;
      else if (roll < 18) b.cmd = deq_pkg::CMD_PUSH_FRONT;
      else if (roll < 26) b.cmd = deq_pkg::CMD_INSERT;
      else if (roll < 44) b.cmd = deq_pkg::CMD_POP_BACK;
      else if (roll < 62) b.cmd = deq_pkg::CMD_POP_FRONT;
      else if (roll < 80) b.cmd = deq_pkg::CMD_ERASE;
      else b.cmd = deq_pkg::CMD_READ_AT;
    end
    if (cnt != 0 && $urandom_range(0, 3) != 0)
      b.position = deq_pkg::PosW'($urandom_range(0, cnt - 1));
    else
      b.position = deq_pkg::PosW'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       b.data_in = '0;
      1:       b.data_in = '1;
      default: b.data_in = $urandom;
    endcase
    return b;
  endfunction

  // alternating growth and drain phases so full and empty both recur
  task automatic test_random(int n_beats);
    bit grow;
    int phase_left;
    grow       = 1'b1;
    phase_left = $urandom_range(20, 60);
    for (int i = 0; i < n_beats; i++) begin
      if (phase_left == 0) begin
        grow       = !grow;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      send_beat(rand_beat(grow));
    end
  endtask

  task automatic test_streaming(int n_beats);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_random(n_beats);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_cases();
    test_positions();
    test_backpressure();
    test_random(1600);
    test_streaming(300);
    wait_drained();
    repeat (60) @(posedge clk);
    if (error_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue.f =====
+incdir+src
src/deq_pkg.sv
src/deq_ctrl.sv
src/deq_datapath.sv
src/double_ended_queue.sv
tb/tb_top.sv
